FILE: design/sjgl_pkg.sv
// Package with shared constants, register codes and structs of the Shift_JIS glyph locator.
`default_nettype none
package sjgl_pkg;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_LANG_MODE  = 2'd0;
  localparam reg_idx_t REG_HALF_BASE  = 2'd1;
  localparam reg_idx_t REG_KANJI_BASE = 2'd2;
  localparam reg_idx_t REG_ADVANCE    = 2'd3;

  localparam logic [4:0] ADVANCE_RESET = 5'd8;

  localparam logic [7:0] LEAD_A_LO  = 8'h81;
  localparam logic [7:0] LEAD_A_HI  = 8'h9f;
  localparam logic [7:0] LEAD_B_LO  = 8'he0;
  localparam logic [7:0] LEAD_B_HI  = 8'hfc;
  localparam logic [7:0] TRAIL_A_LO = 8'h40;
  localparam logic [7:0] TRAIL_A_HI = 8'h7e;
  localparam logic [7:0] TRAIL_B_LO = 8'h80;
  localparam logic [7:0] TRAIL_B_HI = 8'h9e;
  localparam logic [6:0] ROW_B_OFS  = 7'd62;
  localparam logic [8:0] CELL_B_OFS = 9'd63;
  localparam logic [14:0] CELLS_PER_ROW = 15'd94;
  localparam logic [8:0] CELL_C_SUB = 9'd159;
  localparam logic [31:0] KANJI_OFS = 32'd4096;
  localparam logic [31:0] HALF_STEP = 32'd16;

  typedef struct packed {
    logic        lang_mode;
    logic [31:0] half_base;
    logic [31:0] kanji_base;
    logic [4:0]  advance;
  } cfg_t;

  typedef struct packed {
    logic [31:0] glyph_addr;
    logic [12:0] draw_x;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        has_result;
    logic        pair;
    result_t     res0;
    result_t     res1;
    logic [7:0]  lead_nxt;
    logic [11:0] pen_nxt;
  } decode_t;

endpackage
`default_nettype wire

FILE: design/sjgl_cfg_regs.sv
// Configuration register file with its APB-style write and read port.
`default_nettype none
module sjgl_cfg_regs
  import sjgl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lang_mode  <= 1'b0;
      cfg_r.half_base  <= '0;
      cfg_r.kanji_base <= '0;
      cfg_r.advance    <= ADVANCE_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_LANG_MODE:  cfg_r.lang_mode  <= pwdata[0];
        REG_HALF_BASE:  cfg_r.half_base  <= pwdata;
        REG_KANJI_BASE: cfg_r.kanji_base <= pwdata;
        REG_ADVANCE:    cfg_r.advance    <= pwdata[4:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LANG_MODE:  prdata = {31'd0, cfg_r.lang_mode};
      REG_HALF_BASE:  prdata = cfg_r.half_base;
      REG_KANJI_BASE: prdata = cfg_r.kanji_base;
      REG_ADVANCE:    prdata = {27'd0, cfg_r.advance};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/sjgl_decode.sv
// Combinational byte decoder: glyph addresses, draw positions and next state.
`default_nettype none
module sjgl_decode
  import sjgl_pkg::*;
(
  input  wire logic [7:0]  code,
  input  wire logic        new_string,
  input  wire logic [11:0] start_x,
  input  wire logic [7:0]  lead,
  input  wire logic [11:0] pen,
  input  cfg_t             cfg,
  output decode_t          dec
);

  logic [11:0] pen_cur;
  logic        is_lead;
  logic        lead_a;
  logic [7:0]  lead_ofs;
  logic [6:0]  row_base;
  logic [6:0]  row;
  logic [8:0]  col;
  logic [14:0] idx;
  logic [31:0] pair_addr;
  logic [31:0] single_base;

  assign pen_cur = new_string ? start_x : pen;
  assign is_lead = ((code >= LEAD_A_LO) && (code <= LEAD_A_HI)) ||
                   ((code >= LEAD_B_LO) && (code <= LEAD_B_HI));

  // Row of the 94-cell table; only valid lead bytes are ever held.
  assign lead_a   = (lead >= LEAD_A_LO) && (lead <= LEAD_A_HI);
  assign lead_ofs = lead_a ? (lead - LEAD_A_LO) : (lead - LEAD_B_LO);
  assign row_base = lead_a ? {lead_ofs[5:0], 1'b0}
                           : ({lead_ofs[5:0], 1'b0} + ROW_B_OFS);

  // Cell index is signed: malformed trail bytes below 0x9f give a negative cell.
  always_comb begin
    row = row_base;
    col = {1'b0, code} - CELL_C_SUB;
    if ((code >= TRAIL_A_LO) && (code <= TRAIL_A_HI)) begin
      col = {1'b0, code} - {1'b0, TRAIL_A_LO};
    end else if ((code >= TRAIL_B_LO) && (code <= TRAIL_B_HI)) begin
      col = {1'b0, code} - {1'b0, TRAIL_B_LO} + CELL_B_OFS;
    end else begin
      row = row_base + 7'd1;
    end
  end

  assign idx = {8'd0, row} * CELLS_PER_ROW + {{6{col[8]}}, col};
  assign pair_addr = cfg.kanji_base + KANJI_OFS + {{12{idx[14]}}, idx, 5'd0};
  assign single_base = cfg.lang_mode ? cfg.kanji_base : cfg.half_base;

  always_comb begin
    dec.has_result      = 1'b1;
    dec.pair            = 1'b0;
    dec.lead_nxt        = lead;
    dec.pen_nxt         = pen_cur + {7'd0, cfg.advance};
    dec.res0.glyph_addr = single_base + {20'd0, code, 4'd0};
    dec.res0.draw_x     = {1'b0, pen_cur};
    dec.res0.last       = 1'b1;
    dec.res1.glyph_addr = pair_addr + HALF_STEP;
    dec.res1.draw_x     = {1'b0, pen_cur};
    dec.res1.last       = 1'b1;
    if (cfg.lang_mode) begin
      if (lead == 8'd0) begin
        if (is_lead) begin
          dec.has_result = 1'b0;
          dec.lead_nxt   = code;
        end
      end else begin
        dec.pair            = 1'b1;
        dec.lead_nxt        = 8'd0;
        dec.res0.glyph_addr = pair_addr;
        dec.res0.draw_x     = {1'b0, pen_cur} - {8'd0, cfg.advance};
        dec.res0.last       = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/sjgl_out_stage.sv
// Result register with a second slot for the right half of a double-byte glyph.
`default_nettype none
module sjgl_out_stage
  import sjgl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire logic pair,
  input  result_t   res0,
  input  result_t   res1,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_res
);

  logic    out_v_r, out_v_nxt;
  logic    pend_v_r, pend_v_nxt;
  result_t out_res_r, out_res_nxt;
  result_t pend_res_r, pend_res_nxt;

  assign can_load  = !pend_v_r && (!out_v_r || out_ready);
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_v_nxt    = out_v_r;
    pend_v_nxt   = pend_v_r;
    out_res_nxt  = out_res_r;
    pend_res_nxt = pend_res_r;
    if (load) begin
      out_v_nxt    = 1'b1;
      out_res_nxt  = res0;
      pend_v_nxt   = pair;
      pend_res_nxt = res1;
    end else if (out_v_r && out_ready) begin
      out_v_nxt   = pend_v_r;
      out_res_nxt = pend_res_r;
      pend_v_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

endmodule
`default_nettype wire

FILE: design/shift_jis_glyph_locator.sv
// Top level of the Shift_JIS glyph locator: input register, text state and result stage.
//
//  Channel | Direction | Handshake                 | Payload
//  in      | input     | in_valid / in_ready       | in_code, in_new_string, in_start_x
//  out     | output    | out_valid / out_ready     | out_glyph_addr, out_draw_x, out_last
//  cfg     | input     | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// A byte is captured in the input register at its transaction and decoded as it moves
// into the result register once the result stage has room. While out_ready stays high,
// single-byte glyphs sustain one byte per cycle; a double-byte trail yields two results
// on the single result port, so the next byte waits while the right half is pending.
// Lead bytes produce no result and leave without waiting for the result stage.
// Reset is synchronous and active low; it clears the pen, the held lead byte and
// all three valid flags, and loads the register defaults (advance of eight pixels).
// When out_ready stays low the result register holds and the input register fills,
// after which in_ready drops until the result is taken.
`default_nettype none
module shift_jis_glyph_locator
  import sjgl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_code,
  input  wire logic              in_new_string,
  input  wire logic [11:0]       in_start_x,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [31:0]       out_glyph_addr,
  output logic      [12:0]       out_draw_x,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t        cfg;
  decode_t     dec;
  result_t     out_res;
  logic        can_load;
  logic        consume;
  logic        load;

  // Input register: one accepted byte waiting for decode.
  logic        in_v_r;
  logic [7:0]  in_code_r;
  logic        in_ns_r;
  logic [11:0] in_sx_r;

  // Text state carried from byte to byte.
  logic [7:0]  lead_r;
  logic [11:0] pen_r;

  sjgl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sjgl_decode u_dec (
    .code       (in_code_r),
    .new_string (in_ns_r),
    .start_x    (in_sx_r),
    .lead       (lead_r),
    .pen        (pen_r),
    .cfg        (cfg),
    .dec        (dec)
  );

  // A held byte leaves the input register when it makes no result, or when the
  // result stage has room for its result or pair of results.
  assign consume  = in_v_r && (!dec.has_result || can_load);
  assign load     = consume && dec.has_result;
  assign in_ready = !in_v_r || consume;

  sjgl_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .pair      (dec.pair),
    .res0      (dec.res0),
    .res1      (dec.res1),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_glyph_addr = out_res.glyph_addr;
  assign out_draw_x     = out_res.draw_x;
  assign out_last       = out_res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      lead_r <= 8'd0;
      pen_r  <= 12'd0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (consume) begin
        lead_r <= dec.lead_nxt;
        pen_r  <= dec.pen_nxt;
      end
    end
  end

  // The byte register itself needs no reset; in_v_r qualifies it.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_code_r <= in_code;
      in_ns_r   <= in_new_string;
      in_sx_r   <= in_start_x;
    end
  end

endmodule
`default_nettype wire

FILE: design/sjgl_checker.sv
// Port-level checker of the Shift_JIS glyph locator and its bind statement.
`default_nettype none
module sjgl_checker
  import sjgl_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [31:0]       out_glyph_addr,
  input wire logic [12:0]       out_draw_x,
  input wire logic              out_last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_glyph_addr) &&
                               $stable(out_draw_x) && $stable(out_last))
    else $error("stalled result changed");

  // The left half of a glyph pair is followed at once by its right half.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("right half did not follow left half");

  // The right half lies 16 bytes above the left half.
  a_pair_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_glyph_addr == $past(out_glyph_addr) + HALF_STEP)
    else $error("right half address is not left half plus 16");

  // Reset empties the result stage.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind shift_jis_glyph_locator sjgl_checker u_sjgl_checker (.*);
`default_nettype wire

FILE: verif/sjgl_checker.sv
// Checker for the Shift_JIS glyph locator: tracks registers, predicts glyph results and compares.
`timescale 1ns / 1ps
module sjgl_scoreboard
  import sjgl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_code,
  input  logic              in_new_string,
  input  logic [11:0]       in_start_x,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [31:0]       out_glyph_addr,
  input  logic [12:0]       out_draw_x,
  input  logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                glyphs_checked,
  output int                glyphs_pending
);

  // Shadow copy of the registers and of the text state.
  logic        mode_sjis;
  logic [31:0] half_base;
  logic [31:0] kanji_base;
  logic [4:0]  advance;
  logic [7:0]  held_lead;
  logic [11:0] cursor_x;

  result_t glyph_q[$];

  function automatic logic starts_pair(input logic [7:0] c);
    return (c >= LEAD_A_LO && c <= LEAD_A_HI) || (c >= LEAD_B_LO && c <= LEAD_B_HI);
  endfunction

  task automatic queue_glyph(input logic [31:0] addr, input logic [12:0] x, input logic fin);
    result_t r;
    r.glyph_addr = addr;
    r.draw_x     = x;
    r.last       = fin;
    glyph_q.push_back(r);
  endtask

  task automatic predict_glyphs(input logic [7:0] code, input logic ns, input logic [11:0] sx);
    logic [31:0] row;
    logic [31:0] col;
    logic [31:0] addr;
    if (ns) cursor_x = sx;
    if (!mode_sjis) begin
      queue_glyph(half_base + {20'd0, code, 4'd0}, {1'b0, cursor_x}, 1'b1);
    end else if (held_lead == 8'd0) begin
      if (starts_pair(code)) held_lead = code;
      else queue_glyph(kanji_base + {20'd0, code, 4'd0}, {1'b0, cursor_x}, 1'b1);
    end else begin
      if (held_lead <= LEAD_A_HI) row = ({24'd0, held_lead} - LEAD_A_LO) * 32'd2;
      else row = ({24'd0, held_lead} - LEAD_B_LO) * 32'd2 + ROW_B_OFS;
      if (code >= TRAIL_A_LO && code <= TRAIL_A_HI) begin
        col = {24'd0, code} - TRAIL_A_LO;
      end else if (code >= TRAIL_B_LO && code <= TRAIL_B_HI) begin
        col = {24'd0, code} - TRAIL_B_LO + CELL_B_OFS;
      end else begin
        // Second row of the pair; a malformed low byte wraps the cell around 2^32.
        col = {24'd0, code} - CELL_C_SUB;
        row = row + 32'd1;
      end
      held_lead = 8'd0;
      addr = kanji_base + KANJI_OFS + (row * CELLS_PER_ROW + col) * 32'd32;
      queue_glyph(addr, {1'b0, cursor_x} - {8'd0, advance}, 1'b0);
      queue_glyph(addr + HALF_STEP, {1'b0, cursor_x}, 1'b1);
    end
    cursor_x = cursor_x + {7'd0, advance};
  endtask

  task automatic check_glyph();
    result_t want;
    if (glyph_q.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected glyph: addr %h x %0d last %b", $time,
               out_glyph_addr, $signed(out_draw_x), out_last);
    end else begin
      want = glyph_q.pop_front();
      glyphs_checked++;
      if (out_glyph_addr !== want.glyph_addr) begin
        mismatch_count++;
        $display("%0t: glyph_addr expected %h actual %h", $time,
                 want.glyph_addr, out_glyph_addr);
      end
      if (out_draw_x !== want.draw_x) begin
        mismatch_count++;
        $display("%0t: draw_x expected %0d actual %0d", $time,
                 $signed(want.draw_x), $signed(out_draw_x));
      end
      if (out_last !== want.last) begin
        mismatch_count++;
        $display("%0t: last expected %b actual %b", $time, want.last, out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_sjis      = 1'b0;
      half_base      = '0;
      kanji_base     = '0;
      advance        = ADVANCE_RESET;
      held_lead      = '0;
      cursor_x       = '0;
      mismatch_count = 0;
      glyphs_checked = 0;
      glyph_q.delete();
    end else begin
      // Results leaving now belong to older bytes, so retire them before predicting.
      if (out_valid && out_ready) check_glyph();
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_LANG_MODE:  mode_sjis  = pwdata[0];
          REG_HALF_BASE:  half_base  = pwdata;
          REG_KANJI_BASE: kanji_base = pwdata;
          REG_ADVANCE:    advance    = pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_glyphs(in_code, in_new_string, in_start_x);
    end
    glyphs_pending = glyph_q.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the Shift_JIS glyph locator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb
  import sjgl_pkg::*;
();

  // Watchdog limit in clock cycles. The slowest correct run is roughly 800 bytes at two
  // results each, with the receiver stalling half the time, plus register writes.
  localparam int CYCLE_LIMIT = 300000;
  // Bytes per register setting in the random part; twelve settings give about 800 bytes.
  localparam int SEG_BYTES = 67;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_code;
  logic              in_new_string;
  logic [11:0]       in_start_x;
  logic              out_valid;
  logic              out_ready;
  logic [31:0]       out_glyph_addr;
  logic [12:0]       out_draw_x;
  logic              out_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int glyphs_checked;
  int glyphs_pending;

  // Percentages of cycles in which each side holds back.
  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int settings_used;
  int cycles;
  logic cur_sjis;

  shift_jis_glyph_locator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code        (in_code),
    .in_new_string  (in_new_string),
    .in_start_x     (in_start_x),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_glyph_addr (out_glyph_addr),
    .out_draw_x     (out_draw_x),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  sjgl_scoreboard u_scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code        (in_code),
    .in_new_string  (in_new_string),
    .in_start_x     (in_start_x),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_glyph_addr (out_glyph_addr),
    .out_draw_x     (out_draw_x),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .glyphs_checked (glyphs_checked),
    .glyphs_pending (glyphs_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog ends a hung run; every handshake wait in the stimulus relies on it.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles with %0d results outstanding",
               cycles, glyphs_pending);
      $display("tb: FAIL");
      $finish;
    end
  end

  // The result side stalls at random on every cycle, independent of the sender, so
  // that stalls land on lead bytes, on both halves of a pair and between pairs.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Presents one byte on the input channel and returns at the falling edge after its
  // transaction. Valid stays high afterwards, so back-to-back calls keep it high; the
  // next call or the drain lowers it.
  task automatic push_byte(input logic [7:0] code, input logic ns, input logic [11:0] sx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_code       = code;
    in_new_string = ns;
    in_start_x    = sx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Random byte with an occasional string restart at a random pen position.
  task automatic push_random(input logic [7:0] code);
    push_byte(code, $urandom_range(9) == 0, 12'($urandom_range(4095)));
  endtask

  // Waits until the block is idle: every predicted result taken, then a further wait
  // because a lead byte may still sit in the pipeline without any result.
  task automatic drain();
    in_valid = 1'b0;
    while (glyphs_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // One APB write: setup cycle, then the access cycle that completes on pready.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_setting(input logic mode, input logic [31:0] half,
                               input logic [31:0] kanji, input logic [4:0] adv);
    drain();
    write_reg(REG_LANG_MODE, {31'd0, mode});
    write_reg(REG_HALF_BASE, half);
    write_reg(REG_KANJI_BASE, kanji);
    write_reg(REG_ADVANCE, {27'd0, adv});
    cur_sjis = mode;
    settings_used++;
  endtask

  // Font bases favor the wrap-around corners of the address space.
  function automatic logic [31:0] pick_base();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'hffff_f000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_lead();
    if ($urandom_range(1)) return 8'($urandom_range(LEAD_A_HI, LEAD_A_LO));
    return 8'($urandom_range(LEAD_B_HI, LEAD_B_LO));
  endfunction

  // One character of random text. In Shift_JIS mode most characters are well-formed
  // pairs or single-byte glyphs, the rest malformed pairs and arbitrary bytes.
  task automatic random_char();
    int pick;
    int sub;
    logic [7:0] code;
    pick = $urandom_range(99);
    sub  = $urandom_range(2);
    if (!cur_sjis || pick >= 90) begin
      push_random(8'($urandom_range(255)));
    end else if (pick < 60) begin
      case (sub)
        0: code = 8'($urandom_range(TRAIL_A_HI, TRAIL_A_LO));
        1: code = 8'($urandom_range(TRAIL_B_HI, TRAIL_B_LO));
        default: code = 8'($urandom_range(LEAD_B_HI, TRAIL_B_HI + 1));
      endcase
      push_random(pick_lead());
      push_random(code);
    end else if (pick < 80) begin
      // Bytes outside both lead ranges draw a single glyph from the kanji font.
      case (sub)
        0: code = 8'($urandom_range(TRAIL_B_LO, 0));
        1: code = 8'($urandom_range(LEAD_B_LO - 1, LEAD_A_HI + 1));
        default: code = 8'($urandom_range(255, LEAD_B_HI + 1));
      endcase
      push_random(code);
    end else begin
      // A lead followed by a byte that is no legal trail.
      case (sub)
        0: code = 8'($urandom_range(TRAIL_A_LO - 1, 0));
        1: code = TRAIL_A_HI + 8'd1;
        default: code = 8'($urandom_range(255, LEAD_B_HI + 1));
      endcase
      push_random(pick_lead());
      push_random(code);
    end
  endtask

  initial begin
    int seg_start;
    logic [4:0] adv;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_code       = '0;
    in_new_string = 1'b0;
    in_start_x    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 22;
    recv_idle_pct = 50;
    bytes_sent    = 0;
    settings_used = 0;
    cur_sjis      = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Single-byte mode with a base that makes the address wrap, zero
    // advance, code zero, the top code and a byte that would be a lead in Shift_JIS.
    apply_setting(1'b0, 32'hffff_fff0, 32'h0000_0000, 5'd0);
    push_byte(8'h00, 1'b1, 12'd0);
    push_byte(8'hff, 1'b0, 12'd0);
    push_byte(LEAD_A_LO, 1'b1, 12'hfff);

    // Shift_JIS with the largest advance; a pair restarted at column zero puts its left half left of it.
    apply_setting(1'b1, 32'h0000_0000, 32'hffff_f000, 5'd31);
    push_byte(8'h41, 1'b1, 12'd5);
    push_byte(LEAD_A_LO, 1'b0, 12'd0);      // first row, first cell
    push_byte(TRAIL_A_LO, 1'b0, 12'd0);
    push_byte(LEAD_A_HI, 1'b0, 12'd0);      // last cell of the lower half row
    push_byte(TRAIL_B_HI, 1'b0, 12'd0);
    push_byte(LEAD_A_HI, 1'b0, 12'd0);      // trail that moves to the second row
    push_byte(TRAIL_B_HI + 8'd1, 1'b0, 12'd0);
    push_byte(LEAD_B_LO, 1'b0, 12'd0);
    push_byte(TRAIL_A_HI, 1'b0, 12'd0);
    push_byte(LEAD_B_HI, 1'b0, 12'd0);
    push_byte(LEAD_B_HI, 1'b0, 12'd0);
    push_byte(LEAD_A_LO, 1'b0, 12'd0);      // malformed trail: code zero wraps the cell
    push_byte(8'h00, 1'b0, 12'd0);
    push_byte(LEAD_B_LO, 1'b0, 12'd0);      // malformed trail above the legal range
    push_byte(8'hff, 1'b0, 12'd0);
    push_byte(8'h88, 1'b0, 12'd0);          // a string restart while a lead is held
    push_byte(8'h50, 1'b1, 12'd0);
    push_byte(TRAIL_B_LO, 1'b0, 12'd0);     // bytes between the ranges are single glyphs
    push_byte(8'ha0, 1'b0, 12'd0);
    push_byte(8'hfd, 1'b0, 12'd0);

    // A lead held across a switch to single-byte mode survives and pairs afterwards.
    push_byte(8'h90, 1'b0, 12'd0);
    apply_setting(1'b0, 32'h1234_5670, 32'h0000_0000, 5'd16);
    push_byte(8'h30, 1'b0, 12'd0);
    apply_setting(1'b1, 32'h1234_5670, 32'h8000_0000, 5'd1);
    push_byte(8'h60, 1'b0, 12'd0);

    // Random part in three idle phases, four register settings in each.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 22; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(5))
          0: adv = 5'd0;
          1: adv = 5'd31;
          default: adv = 5'($urandom_range(16, 1));
        endcase
        apply_setting($urandom_range(3) != 0, pick_base(), pick_base(), adv);
        seg_start = bytes_sent;
        while (bytes_sent - seg_start < SEG_BYTES) random_char();
      end
    end

    drain();
    $display("summary: %0d bytes over %0d register settings, %0d glyph results checked",
             bytes_sent, settings_used, glyphs_checked);
    $display("summary: both modes, wrapping bases and advances from 0 to 31 were exercised");
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
